[hdl/tuwt_pkg.sv]
package tuwt_pkg;

    // Result codes
    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_DENIED     = 3'd1;
    localparam logic [2:0] ST_REGISTERED = 3'd2;
    localparam logic [2:0] ST_PRESENT    = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_BAD_CHECK  = 3'd5;

    typedef struct packed {
        logic [31:0] serial_bytes;
        logic [7:0]  check_byte;
    } tuwt_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       lamp_on;
        logic [4:0] entries_used;
    } tuwt_out_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [31:0] serial;
        logic        check_ok;
    } tuwt_job_t;

    function automatic logic [7:0] tuwt_xor_bytes(input logic [31:0] s);
        tuwt_xor_bytes = s[7:0] ^ s[15:8] ^ s[23:16] ^ s[31:24];
    endfunction

endpackage

[hdl/tag_uid_whitelist_table.sv]
// Card serial whitelist.
// Input queue: drive item (serial bytes and check byte) and raise push; the
// beat is taken at a clock edge where push is high and full is low.
// Result queue: while empty is low the oldest result (status, lamp level,
// entries used) sits on result; raise pop to take that beat.
// Mode register: raise mode_we with mode_wdata to pick verify (0) or enrol (1);
// write it only while no item is in flight.
// The back end scans the stored serials through one RAM read port, one entry
// a cycle, for an item with a good check byte and a non-empty table; a bad
// check byte or an empty table skips the scan.
// Both sides have two-entry queues, so a new beat is taken while a result
// still waits; a stalled receiver backs the work up into the input queue and
// then raises full.
// Reset clears the table count, the lamp and the mode; serial storage is not
// cleared, entries at or beyond the count are never read.
module tag_uid_whitelist_table
    import tuwt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tuwt_in_t  item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output tuwt_out_t result,
    input  logic      mode_we,
    input  logic      mode_wdata
);

    logic                          mode_reg;
    tuwt_job_t                     job;
    logic                          job_empty;
    logic                          job_pop;
    logic                          res_full;
    logic                          res_push;
    tuwt_out_t                     res;
    logic [$bits(tuwt_out_t)-1:0]  res_q;

    // Mode register: hold until rewritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (mode_we)
        begin
            mode_reg <= mode_wdata;
        end
    end

    // Front: check the beat and queue it
    tuwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .job_pop   (job_pop),
        .job       (job),
        .job_empty (job_empty)
    );

    // Back: scan the table, update it and form the result
    tuwt_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .job       (job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue decouples the back end from a stalling receiver
    tuwt_fifo #(
        .W($bits(tuwt_out_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_q),
        .empty (empty)
    );

    assign result = tuwt_out_t'(res_q);

endmodule

[hdl/tuwt_ram.sv]
module tuwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tuwt_fifo.sv]
module tuwt_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    // Two-entry queue: one beat may wait while the next is taken
    logic [W-1:0] slot_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

[hdl/tuwt_front.sv]
module tuwt_front
    import tuwt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tuwt_in_t  item,
    output logic      full,
    input  logic      job_pop,
    output tuwt_job_t job,
    output logic      job_empty
);

    tuwt_job_t                     job_in;
    logic [$bits(tuwt_job_t)-1:0]  q_rdata;

    // Classify: check byte against XOR of the serial bytes
    always_comb
    begin
        job_in.serial   = item.serial_bytes;
        job_in.check_ok = (tuwt_xor_bytes(item.serial_bytes) == item.check_byte);
    end

    tuwt_fifo #(
        .W($bits(tuwt_job_t))
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .full  (full),
        .pop   (job_pop),
        .rdata (q_rdata),
        .empty (job_empty)
    );

    assign job = tuwt_job_t'(q_rdata);

endmodule

[hdl/tuwt_back.sv]
module tuwt_back
    import tuwt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mode,
    input  tuwt_job_t job,
    input  logic      job_empty,
    output logic      job_pop,
    input  logic      res_full,
    output logic      res_push,
    output tuwt_out_t res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] idx_inc;
    logic          lamp_reg, lamp_next;
    logic          found_reg, found_next;
    logic          rd_vld_reg;
    logic [31:0]   serial_reg;
    logic          ok_reg;
    logic          rd_en;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [2:0]    status;
    logic [CW+4:0] count_ext;

    assign idx_inc = idx_reg + 1'b1;
    assign rd_en   = (state_reg == S_SCAN);
    assign job_pop = (state_reg == S_IDLE) && !job_empty && !res_full;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        lamp_next  = lamp_reg;
        found_next = found_reg | (rd_vld_reg && (rd_data == serial_reg));
        wr_en      = 1'b0;
        res_push   = 1'b0;
        status     = ST_BAD_CHECK;
        case (state_reg)
            S_IDLE:
            begin
                if (job_pop)
                begin
                    found_next = 1'b0;
                    idx_next   = '0;
                    if (!job.check_ok || (count_reg == '0))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                idx_next = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
                if (!ok_reg)
                begin
                    status = ST_BAD_CHECK;
                end
                else if (mode)
                begin
                    if (found_reg)
                    begin
                        status = ST_PRESENT;
                    end
                    else if (count_reg < DEPTH_C)
                    begin
                        status     = ST_REGISTERED;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        status = ST_FULL;
                    end
                end
                else if (found_reg)
                begin
                    status    = ST_GRANTED;
                    lamp_next = 1'b1;
                end
                else
                begin
                    status    = ST_DENIED;
                    lamp_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entries used is the count taken to five bits
    assign count_ext = {5'b0, count_next};

    always_comb
    begin
        res.status       = status;
        res.lamp_on      = lamp_next;
        res.entries_used = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            lamp_reg   <= 1'b0;
            found_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            lamp_reg   <= lamp_next;
            found_reg  <= found_next;
            rd_vld_reg <= rd_en;
        end
    end

    // Hold the item under work
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            serial_reg <= job.serial;
            ok_reg     <= job.check_ok;
        end
    end

    tuwt_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (serial_reg),
        .re    (rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench
    import tuwt_pkg::*;
();

    localparam int DEPTH = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    tuwt_in_t  item = '0;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    tuwt_out_t result;
    logic      mode_we = 1'b0;
    logic      mode_wdata = 1'b0;

    tag_uid_whitelist_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tags waiting to be offered, and the verdicts owed by the block in order
    tuwt_in_t  tags_waiting[$];
    tuwt_out_t verdicts_owed[$];

    // Shadow of the whitelist, the lamp and the mode register
    logic [31:0] whitelist [DEPTH];
    int          whitelist_count = 0;
    logic        lamp_lit = 1'b0;
    logic        enrol_mode = 1'b0;

    int fault_count = 0;

    // Serials known to be enrolled, used to build hits and near misses
    logic [31:0] roster[$];

    // XOR of the four serial bytes, which a sound check byte must equal
    function automatic logic [7:0] fold_bytes(logic [31:0] s);
        return s[31:24] ^ s[23:16] ^ s[15:8] ^ s[7:0];
    endfunction

    // Work out the verdict for one accepted tag and advance the shadow state
    function automatic tuwt_out_t judge_tag(tuwt_in_t t);
        tuwt_out_t v;
        bit        known;
        known = 1'b0;
        if (fold_bytes(t.serial_bytes) != t.check_byte)
        begin
            v.status = ST_BAD_CHECK;
        end
        else
        begin
            for (int k = 0; k < whitelist_count; k++)
            begin
                if (whitelist[k] == t.serial_bytes)
                    known = 1'b1;
            end
            if (enrol_mode)
            begin
                if (known)
                    v.status = ST_PRESENT;
                else if (whitelist_count < DEPTH)
                begin
                    whitelist[whitelist_count] = t.serial_bytes;
                    whitelist_count++;
                    v.status = ST_REGISTERED;
                end
                else
                    v.status = ST_FULL;
            end
            else
            begin
                // verify mode drives the lamp from the lookup
                v.status = known ? ST_GRANTED : ST_DENIED;
                lamp_lit = known;
            end
        end
        v.lamp_on      = lamp_lit;
        v.entries_used = whitelist_count[4:0];
        return v;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic tuwt_in_t tag_sound(logic [31:0] s);
        tuwt_in_t t;
        t.serial_bytes = s;
        t.check_byte   = fold_bytes(s);
        return t;
    endfunction

    // Corrupt the check byte by a nonzero pattern
    function automatic tuwt_in_t tag_corrupt(logic [31:0] s, logic [7:0] flip);
        tuwt_in_t t;
        t.serial_bytes = s;
        t.check_byte   = fold_bytes(s) ^ flip;
        return t;
    endfunction

    task automatic log_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Sender: offer queued tags one beat at a time, with random idle gaps.
    // While a beat is held against full, leave push and item untouched.
    // ------------------------------------------------------------------
    int send_gap = 0;
    int send_calm = 0;

    always @(posedge clk)
    begin
        if (rst_n && !(push && full))
        begin
            if (push)
            begin
                // beat taken at this edge: predict its verdict now
                verdicts_owed.push_back(judge_tag(item));
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = idle_len();
                    if ($urandom_range(0, 49) == 0)
                        send_calm = $urandom_range(20, 80);
                end
            end
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (tags_waiting.size() != 0)
            begin
                item <= tags_waiting.pop_front();
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: take verdict beats and compare each with the oldest one
    // owed. Twice in the run, hold pop low for a long stretch so that the
    // block backs up and raises full while the sender keeps offering.
    // ------------------------------------------------------------------
    int        recv_gap = 0;
    int        recv_calm = 0;
    int        hold_left = 0;
    int        beats_taken = 0;
    tuwt_out_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (verdicts_owed.size() == 0)
                    log_fault($sformatf("unexpected verdict status %0d lamp %0d used %0d",
                        result.status, result.lamp_on, result.entries_used));
                else
                begin
                    want = verdicts_owed.pop_front();
                    if (result.status !== want.status || result.lamp_on !== want.lamp_on
                        || result.entries_used !== want.entries_used)
                        log_fault($sformatf(
                            "verdict %0d: want status %0d lamp %0d used %0d, got %0d %0d %0d",
                            beats_taken, want.status, want.lamp_on, want.entries_used,
                            result.status, result.lamp_on, result.entries_used));
                end
                beats_taken++;
                if (beats_taken == 120 || beats_taken == 800)
                    hold_left = 400;
                else if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_gap = 0;
                end
                else
                begin
                    recv_gap = idle_len();
                    if ($urandom_range(0, 49) == 0)
                        recv_calm = $urandom_range(20, 80);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. Queue handling and idle checks run on the falling edge so
    // they never race the clocked sender and receiver.
    // ------------------------------------------------------------------

    // Wait until every tag is taken and every verdict has come back
    task automatic settle();
        do
            @(negedge clk);
        while (tags_waiting.size() != 0 || push || verdicts_owed.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(logic v);
        @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= v;
        @(posedge clk);
        mode_we    <= 1'b0;
        enrol_mode = v;
        @(negedge clk);
    endtask

    initial
    begin
        int          phase;
        int          span;
        int          sent;
        int          r;
        logic [31:0] s;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Verify on an empty table: extremes deny, a bad check byte is refused
        tags_waiting.push_back(tag_sound(32'h0000_0000));
        tags_waiting.push_back(tag_sound(32'hFFFF_FFFF));
        tags_waiting.push_back(tag_corrupt(32'h1234_5678, 8'hFF));
        settle();

        // Enrol the extremes, repeat one, and refuse a bad check in enrol mode
        set_mode(1'b1);
        tags_waiting.push_back(tag_sound(32'h0000_0000));
        tags_waiting.push_back(tag_sound(32'hFFFF_FFFF));
        tags_waiting.push_back(tag_sound(32'h0000_0000));
        tags_waiting.push_back(tag_corrupt(32'hFFFF_FFFF, 8'h01));
        roster.push_back(32'h0000_0000);
        roster.push_back(32'hFFFF_FFFF);
        settle();

        // Verify: grant lights the lamp, a bad check leaves it, a deny drops it
        set_mode(1'b0);
        tags_waiting.push_back(tag_sound(32'hFFFF_FFFF));
        tags_waiting.push_back(tag_corrupt(32'h8000_0001, 8'h80));
        tags_waiting.push_back(tag_sound(32'hA5A5_A5A5));
        tags_waiting.push_back(tag_sound(32'h0000_0000));
        settle();

        // Fill the table, overflow it, and repeat a stored serial when full
        set_mode(1'b1);
        for (int k = 0; k < DEPTH - 2; k++)
        begin
            s = $urandom;
            roster.push_back(s);
            tags_waiting.push_back(tag_sound(s));
        end
        tags_waiting.push_back(tag_sound($urandom));
        tags_waiting.push_back(tag_sound(32'hFFFF_FFFF));
        settle();

        // Random phases, each in one mode, with a full drain between them
        sent = 0;
        phase = 0;
        while (sent < 1370)
        begin
            if (phase == 0)
                set_mode(1'b0);
            else if (phase == 1)
                set_mode(1'b1);
            else
                set_mode(1'($urandom_range(0, 1)));
            span = $urandom_range(40, 200);
            for (int k = 0; k < span; k++)
            begin
                r = $urandom_range(0, 99);
                s = roster[$urandom_range(0, roster.size() - 1)];
                if (r < 35)
                    tags_waiting.push_back(tag_sound(s));
                else if (r < 55)
                    // near miss: one serial bit off a stored entry
                    tags_waiting.push_back(tag_sound(s ^ (32'h1 << $urandom_range(0, 31))));
                else if (r < 75)
                    tags_waiting.push_back(tag_sound($urandom));
                else if (r < 87)
                    tags_waiting.push_back(tag_corrupt(s, 8'($urandom_range(1, 255))));
                else
                    tags_waiting.push_back(tag_corrupt($urandom,
                        8'($urandom_range(1, 255))));
            end
            sent += span;
            phase++;
            settle();
        end

        // Let any stray beat surface before the verdict
        repeat (40) @(posedge clk);
        if (verdicts_owed.size() != 0)
            log_fault($sformatf("%0d verdicts never came", verdicts_owed.size()));
        if (fault_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
